FILE: hdl/otpt_pkg.sv
// Shared constants, codes and control types for the timer table.
`default_nettype none

package otpt_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int TIME_BITS = 32;
   localparam int ID_BITS   = 16;
   localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam int OP_BITS       = 2;
   localparam int NOW_BITS      = 32;
   localparam int DELAY_BITS    = 32;
   localparam int CID_BITS      = 16;
   localparam int STATUS_BITS   = 3;
   localparam int TID_BITS      = 16;
   localparam int SLOT_OUT_BITS = 4;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD_ONESHOT  = 2'd0,
      OP_ADD_PERIODIC = 2'd1,
      OP_CANCEL       = 2'd2,
      OP_TICK         = 2'd3
   } otpt_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ADDED     = 3'd0,
      ST_FULL      = 3'd1,
      ST_CANCELLED = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FIRED     = 3'd4
   } otpt_status_type;

   typedef enum logic [1:0] {
      SCAN_CANCEL,
      SCAN_PERIODIC,
      SCAN_ONESHOT
   } otpt_scan_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_CANCEL,
      S_TICK_PER,
      S_TICK_ONE,
      S_FLUSH
   } otpt_state_type;

   typedef struct packed {
      logic          load;
      logic          add;
      logic          cancel_hit;
      logic          cancel_miss;
      logic          fire;
      logic          push_mid;
      logic          push_last;
      logic          idx_step;
      otpt_scan_type mode;
   } otpt_cmd_type;

   typedef struct packed {
      logic hit_cancel;
      logic hit_periodic;
      logic hit_oneshot;
      logic idx_end;
      logic pend_valid;
      logic out_free;
   } otpt_stat_type;

endpackage

`default_nettype wire

FILE: hdl/otpt_ctrl.sv
// Sequencer for the timer table: accepts a request and steps the slot scans.
`default_nettype none

module otpt_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [otpt_pkg::OP_BITS-1:0] req_op,
   input  wire otpt_pkg::otpt_stat_type      stat,
   output otpt_pkg::otpt_cmd_type            cmd
);

   otpt_pkg::otpt_state_type state_ff, state_in;
   logic                     hit;
   logic                     scan_go;

   always_comb begin
      unique case (state_ff)
         otpt_pkg::S_CANCEL:   hit = stat.hit_cancel;
         otpt_pkg::S_TICK_PER: hit = stat.hit_periodic;
         otpt_pkg::S_TICK_ONE: hit = stat.hit_oneshot;
         default:              hit = 1'b0;
      endcase
   end

   // a hit with the holding slot full waits for the output register
   assign scan_go = !(hit && stat.pend_valid && !stat.out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= otpt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         otpt_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (otpt_pkg::otpt_op_type'(req_op))
                  otpt_pkg::OP_ADD_ONESHOT,
                  otpt_pkg::OP_ADD_PERIODIC: state_in = otpt_pkg::S_ADD;
                  otpt_pkg::OP_CANCEL:       state_in = otpt_pkg::S_CANCEL;
                  otpt_pkg::OP_TICK:         state_in = otpt_pkg::S_TICK_PER;
                  default:                   state_in = otpt_pkg::S_IDLE;
               endcase
            end
         end
         otpt_pkg::S_ADD: state_in = otpt_pkg::S_FLUSH;
         otpt_pkg::S_CANCEL: begin
            if (hit || stat.idx_end) begin
               state_in = otpt_pkg::S_FLUSH;
            end
         end
         otpt_pkg::S_TICK_PER: begin
            if (scan_go && stat.idx_end) begin
               state_in = otpt_pkg::S_TICK_ONE;
            end
         end
         otpt_pkg::S_TICK_ONE: begin
            if (scan_go && stat.idx_end) begin
               state_in = otpt_pkg::S_FLUSH;
            end
         end
         otpt_pkg::S_FLUSH: begin
            if (!stat.pend_valid || stat.out_free) begin
               state_in = otpt_pkg::S_IDLE;
            end
         end
         default: state_in = otpt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.mode  = otpt_pkg::SCAN_CANCEL;
      req_ready = 1'b0;
      unique case (state_ff)
         otpt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         otpt_pkg::S_ADD: begin
            cmd.add = 1'b1;
         end
         otpt_pkg::S_CANCEL: begin
            cmd.mode = otpt_pkg::SCAN_CANCEL;
            if (hit) begin
               cmd.cancel_hit = 1'b1;
            end else if (stat.idx_end) begin
               cmd.cancel_miss = 1'b1;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         otpt_pkg::S_TICK_PER,
         otpt_pkg::S_TICK_ONE: begin
            cmd.mode = (state_ff == otpt_pkg::S_TICK_PER) ? otpt_pkg::SCAN_PERIODIC
                                                          : otpt_pkg::SCAN_ONESHOT;
            if (scan_go) begin
               cmd.fire     = hit;
               cmd.push_mid = hit && stat.pend_valid;
               cmd.idx_step = 1'b1;
            end
         end
         otpt_pkg::S_FLUSH: begin
            cmd.push_last = stat.pend_valid && stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/otpt_dpath.sv
// Timer table storage, slot scan compare, result holding and output registers.
`default_nettype none

module otpt_dpath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire otpt_pkg::otpt_cmd_type           cmd,
   output otpt_pkg::otpt_stat_type               stat,
   input  wire logic [otpt_pkg::OP_BITS-1:0]     req_op,
   input  wire logic [otpt_pkg::NOW_BITS-1:0]    req_now,
   input  wire logic [otpt_pkg::DELAY_BITS-1:0]  req_delay,
   input  wire logic [otpt_pkg::CID_BITS-1:0]    req_cancel_id,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [otpt_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [otpt_pkg::TID_BITS-1:0]         rsp_timer_id,
   output logic [otpt_pkg::SLOT_OUT_BITS-1:0]    rsp_slot,
   output logic                                  rsp_last
);

   localparam int NS = otpt_pkg::NUM_SLOTS;
   localparam int TB = otpt_pkg::TIME_BITS;
   localparam int IB = otpt_pkg::ID_BITS;
   localparam int SB = otpt_pkg::SLOT_BITS;

   // request latch
   logic [otpt_pkg::OP_BITS-1:0] op_ff,  op_in;
   logic [TB-1:0]                now_ff, now_in;
   logic [TB-1:0]                dly_ff, dly_in;
   logic [IB-1:0]                cid_ff, cid_in;

   // slot table
   logic [NS-1:0] slot_valid_ff, slot_valid_in;
   logic [NS-1:0] slot_periodic_ff, slot_periodic_in;
   logic [IB-1:0] slot_id_ff [NS];
   logic [IB-1:0] slot_id_in [NS];
   logic [TB-1:0] slot_deadline_ff [NS];
   logic [TB-1:0] slot_deadline_in [NS];
   logic [TB-1:0] slot_period_ff [NS];
   logic [TB-1:0] slot_period_in [NS];
   logic [IB-1:0] next_id_ff, next_id_in;
   logic [SB-1:0] idx_ff, idx_in;

   // holding slot for the newest result
   logic                      pend_valid_ff, pend_valid_in;
   otpt_pkg::otpt_status_type pend_status_ff, pend_status_in;
   logic [IB-1:0]             pend_id_ff, pend_id_in;
   logic [SB-1:0]             pend_slot_ff, pend_slot_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [otpt_pkg::STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [otpt_pkg::TID_BITS-1:0]     rsp_id_ff, rsp_id_in;
   logic [otpt_pkg::SLOT_OUT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic          cur_valid, cur_per, due, full;
   logic [IB-1:0] cur_id;
   logic [TB-1:0] cur_dl, cur_pd, diff;
   logic [SB-1:0] free_idx;

   assign cur_valid = slot_valid_ff[idx_ff];
   assign cur_per   = slot_periodic_ff[idx_ff];
   assign cur_id    = slot_id_ff[idx_ff];
   assign cur_dl    = slot_deadline_ff[idx_ff];
   assign cur_pd    = slot_period_ff[idx_ff];
   assign diff      = now_ff - cur_dl;
   assign due       = (diff != '0) && !diff[TB-1];
   assign full      = &slot_valid_ff;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = SB'(i);
         end
      end
   end

   always_comb begin
      stat.hit_cancel   = cur_valid && (cur_id == cid_ff);
      stat.hit_periodic = cur_valid && cur_per && due;
      stat.hit_oneshot  = cur_valid && !cur_per && due;
      stat.idx_end      = (idx_ff == SB'(NS - 1));
      stat.pend_valid   = pend_valid_ff;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in  = op_ff;
      now_in = now_ff;
      dly_in = dly_ff;
      cid_in = cid_ff;
      if (cmd.load) begin
         op_in  = req_op;
         now_in = TB'(req_now);
         dly_in = TB'(req_delay);
         cid_in = IB'(req_cancel_id);
      end
   end

   always_comb begin
      slot_valid_in    = slot_valid_ff;
      slot_periodic_in = slot_periodic_ff;
      slot_id_in       = slot_id_ff;
      slot_deadline_in = slot_deadline_ff;
      slot_period_in   = slot_period_ff;
      next_id_in       = next_id_ff;
      idx_in           = idx_ff;
      pend_valid_in    = pend_valid_ff;
      pend_status_in   = pend_status_ff;
      pend_id_in       = pend_id_ff;
      pend_slot_in     = pend_slot_ff;

      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = stat.idx_end ? '0 : idx_ff + SB'(1);
      end

      if (cmd.add) begin
         pend_valid_in = 1'b1;
         if (full) begin
            pend_status_in = otpt_pkg::ST_FULL;
            pend_id_in     = '0;
            pend_slot_in   = '0;
         end else begin
            slot_valid_in[free_idx]    = 1'b1;
            slot_periodic_in[free_idx] =
               (otpt_pkg::otpt_op_type'(op_ff) == otpt_pkg::OP_ADD_PERIODIC);
            slot_id_in[free_idx]       = next_id_ff;
            slot_deadline_in[free_idx] = now_ff + dly_ff;
            slot_period_in[free_idx]   = dly_ff;
            pend_status_in             = otpt_pkg::ST_ADDED;
            pend_id_in                 = next_id_ff;
            pend_slot_in               = free_idx;
            next_id_in                 = next_id_ff + IB'(1);
         end
      end

      if (cmd.cancel_hit) begin
         slot_valid_in[idx_ff] = 1'b0;
         pend_valid_in         = 1'b1;
         pend_status_in        = otpt_pkg::ST_CANCELLED;
         pend_id_in            = cid_ff;
         pend_slot_in          = idx_ff;
      end

      if (cmd.cancel_miss) begin
         pend_valid_in  = 1'b1;
         pend_status_in = otpt_pkg::ST_NOT_FOUND;
         pend_id_in     = cid_ff;
         pend_slot_in   = '0;
      end

      if (cmd.fire) begin
         pend_valid_in  = 1'b1;
         pend_status_in = otpt_pkg::ST_FIRED;
         pend_id_in     = cur_id;
         pend_slot_in   = idx_ff;
         if (cmd.mode == otpt_pkg::SCAN_PERIODIC) begin
            slot_deadline_in[idx_ff] = now_ff + cur_pd;
         end else begin
            slot_valid_in[idx_ff] = 1'b0;
         end
      end

      if (cmd.push_last) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.push_mid || cmd.push_last) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_id_in     = otpt_pkg::TID_BITS'(pend_id_ff);
         rsp_slot_in   = otpt_pkg::SLOT_OUT_BITS'(pend_slot_ff);
         rsp_last_in   = cmd.push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff    <= '0;
         slot_periodic_ff <= '0;
         next_id_ff       <= '0;
         idx_ff           <= '0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         slot_valid_ff    <= slot_valid_in;
         slot_periodic_ff <= slot_periodic_in;
         next_id_ff       <= next_id_in;
         idx_ff           <= idx_in;
         pend_valid_ff    <= pend_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      now_ff           <= now_in;
      dly_ff           <= dly_in;
      cid_ff           <= cid_in;
      slot_id_ff       <= slot_id_in;
      slot_deadline_ff <= slot_deadline_in;
      slot_period_ff   <= slot_period_in;
      pend_status_ff   <= pend_status_in;
      pend_id_ff       <= pend_id_in;
      pend_slot_ff     <= pend_slot_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_id_ff        <= rsp_id_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_timer_id = rsp_id_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/oneshot_periodic_timer_table.sv
// Timer table with one-shot and periodic slots: top level.
//
// One request at a time. An add passes through S_ADD and S_FLUSH before the next
// request is taken; a cancel walks the slots one per cycle until a hit or the last
// slot; a tick walks the table twice (periodic slots, then one-shot slots), and
// stalls on a hit while the holding slot and the output register are both full.
// Each request also waits while the result side holds off rsp_ready with a result
// waiting. The scan reads through a single slot-read port. Each result beat carries
// rsp_last on the final beat of its request; a tick that fires nothing gives no beats.
`default_nettype none

module oneshot_periodic_timer_table (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [otpt_pkg::OP_BITS-1:0]        req_op,
   input  wire logic [otpt_pkg::NOW_BITS-1:0]       req_now,
   input  wire logic [otpt_pkg::DELAY_BITS-1:0]     req_delay,
   input  wire logic [otpt_pkg::CID_BITS-1:0]       req_cancel_id,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [otpt_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [otpt_pkg::TID_BITS-1:0]            rsp_timer_id,
   output logic [otpt_pkg::SLOT_OUT_BITS-1:0]       rsp_slot,
   output logic                                     rsp_last
);

   otpt_pkg::otpt_cmd_type  cmd;
   otpt_pkg::otpt_stat_type stat;

   otpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .stat      (stat),
      .cmd       (cmd)
   );

   otpt_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_op        (req_op),
      .req_now       (req_now),
      .req_delay     (req_delay),
      .req_cancel_id (req_cancel_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_timer_id  (rsp_timer_id),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

FILE: test/timer_table_checker.sv
// Timer table checker: mirrors the slot table from accepted requests and scores every result beat.
module timer_table_checker
   import otpt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic [OP_BITS-1:0]         req_op,
   input  wire logic [NOW_BITS-1:0]        req_now,
   input  wire logic [DELAY_BITS-1:0]      req_delay,
   input  wire logic [CID_BITS-1:0]        req_cancel_id,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [STATUS_BITS-1:0]     rsp_status,
   input  wire logic [TID_BITS-1:0]        rsp_timer_id,
   input  wire logic [SLOT_OUT_BITS-1:0]   rsp_slot,
   input  wire logic                       rsp_last,
   output int                              error_count,
   output int                              awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      otpt_status_type            status;
      logic [TID_BITS-1:0]        timer_id;
      logic [SLOT_OUT_BITS-1:0]   slot;
      logic                       last;
   } timer_rsp_type;

   logic                  slot_live     [NUM_SLOTS];
   logic                  slot_repeats  [NUM_SLOTS];
   logic [ID_BITS-1:0]    slot_tid      [NUM_SLOTS];
   logic [TIME_BITS-1:0]  slot_due_at   [NUM_SLOTS];
   logic [TIME_BITS-1:0]  slot_interval [NUM_SLOTS];
   logic [ID_BITS-1:0]    id_next;
   timer_rsp_type         awaited_rsp [$];
   timer_rsp_type         held_rsp;
   logic                  held_full;
   timer_rsp_type         want;

   // wrap-safe: strictly behind now by less than half the time range
   function automatic logic past_due(input logic [TIME_BITS-1:0] deadline,
                                     input logic [TIME_BITS-1:0] stamp);
      logic [TIME_BITS-1:0] lag;
      lag = stamp - deadline;
      return (lag != '0) && !lag[TIME_BITS-1];
   endfunction

   // one beat is held back so the final beat of a request can be marked last
   function automatic void queue_rsp(input otpt_status_type code,
                                     input logic [ID_BITS-1:0] id, input int idx);
      if (held_full)
         awaited_rsp.push_back(held_rsp);
      held_rsp.status   = code;
      held_rsp.timer_id = id;
      held_rsp.slot     = idx[SLOT_OUT_BITS-1:0];
      held_rsp.last     = 1'b0;
      held_full         = 1'b1;
   endfunction

   function automatic void apply_timer_req(input otpt_op_type op,
                                           input logic [TIME_BITS-1:0] stamp,
                                           input logic [TIME_BITS-1:0] span,
                                           input logic [ID_BITS-1:0] cid);
      int hit;
      hit       = -1;
      held_full = 1'b0;
      case (op)
         OP_ADD_ONESHOT, OP_ADD_PERIODIC: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (hit < 0 && !slot_live[i])
                  hit = i;
            if (hit < 0) begin
               queue_rsp(ST_FULL, '0, 0);
            end else begin
               slot_live[hit]     = 1'b1;
               slot_repeats[hit]  = (op == OP_ADD_PERIODIC);
               slot_tid[hit]      = id_next;
               slot_due_at[hit]   = stamp + span;
               slot_interval[hit] = span;
               queue_rsp(ST_ADDED, id_next, hit);
               id_next = id_next + 1'b1;
            end
         end
         OP_CANCEL: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (hit < 0 && slot_live[i] && slot_tid[i] == cid)
                  hit = i;
            if (hit < 0) begin
               queue_rsp(ST_NOT_FOUND, cid, 0);
            end else begin
               slot_live[hit] = 1'b0;
               queue_rsp(ST_CANCELLED, cid, hit);
            end
         end
         default: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_live[i] && slot_repeats[i] && past_due(slot_due_at[i], stamp)) begin
                  queue_rsp(ST_FIRED, slot_tid[i], i);
                  slot_due_at[i] = stamp + slot_interval[i];
               end
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_live[i] && !slot_repeats[i] && past_due(slot_due_at[i], stamp)) begin
                  queue_rsp(ST_FIRED, slot_tid[i], i);
                  slot_live[i] = 1'b0;
               end
         end
      endcase
      if (held_full) begin
         held_rsp.last = 1'b1;
         awaited_rsp.push_back(held_rsp);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i]     = 1'b0;
            slot_repeats[i]  = 1'b0;
            slot_tid[i]      = '0;
            slot_due_at[i]   = '0;
            slot_interval[i] = '0;
         end
         id_next = '0;
         awaited_rsp.delete();
      end else begin
         if (req_valid && req_ready)
            apply_timer_req(otpt_op_type'(req_op), req_now, req_delay, req_cancel_id);
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("unexpected beat: status %0d timer_id %0d slot %0d last %0d",
                      rsp_status, rsp_timer_id, rsp_slot, rsp_last);
               error_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_timer_id !== want.timer_id) begin
                  $error("timer_id: expected %0d, got %0d", want.timer_id, rsp_timer_id);
                  error_count++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
      awaited_count = awaited_rsp.size();
   end

endmodule

FILE: test/oneshot_periodic_timer_table_test.sv
// Timer table testbench top: clock, reset, request and response drivers, verdict.
module oneshot_periodic_timer_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import otpt_pkg::*;

   localparam int                   LIMIT_CYCLES = 200_000;
   localparam int                   HOLD_CYCLES  = 400;
   localparam int                   RANDOM_REQS  = 54;
   // anchor id 0 in slot 0, then fill and drain slots 1..15 twice
   localparam int                   FILL_ROUNDS  = 2;
   localparam logic [TIME_BITS-1:0] BASE_T       = 32'h0000_1000;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic [OP_BITS-1:0]         req_op        = '0;
   logic [NOW_BITS-1:0]        req_now       = '0;
   logic [DELAY_BITS-1:0]      req_delay     = '0;
   logic [CID_BITS-1:0]        req_cancel_id = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [STATUS_BITS-1:0]     rsp_status;
   logic [TID_BITS-1:0]        rsp_timer_id;
   logic [SLOT_OUT_BITS-1:0]   rsp_slot;
   logic                       rsp_last;

   int                         req_idle_pct  = 0;
   int                         rsp_idle_pct  = 0;
   logic                       hold_toggle   = 1'b0;
   logic                       hold_seen     = 1'b0;
   int                         hold_left     = 0;
   int                         cycle_count   = 0;
   int                         error_count;
   int                         awaited_count;
   logic [TIME_BITS-1:0]       tick_now      = '0;
   logic [ID_BITS-1:0]         id_guess      = '0;

   oneshot_periodic_timer_table i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_now       (req_now),
      .req_delay     (req_delay),
      .req_cancel_id (req_cancel_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_timer_id  (rsp_timer_id),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

   timer_table_checker i_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_now       (req_now),
      .req_delay     (req_delay),
      .req_cancel_id (req_cancel_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_timer_id  (rsp_timer_id),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last),
      .error_count   (error_count),
      .awaited_count (awaited_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("oneshot_periodic_timer_table_test: errors");
         $finish;
      end
   end

   // result side: random stalls, or a long hold-off when the top asks for one
   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_req(input otpt_op_type op, input logic [TIME_BITS-1:0] stamp,
                           input logic [TIME_BITS-1:0] span, input logic [ID_BITS-1:0] cid);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_now       <= stamp;
      req_delay     <= span;
      req_cancel_id <= cid;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic pause_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_count != 0)
         @(negedge clock);
   endtask

   // time mostly creeps forward so deadlines come due; now and then it jumps
   task automatic send_random_req();
      int                   pick;
      logic [TIME_BITS-1:0] span;
      logic [ID_BITS-1:0]   cid;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 24) == 0)
         tick_now = $urandom;
      else
         tick_now = tick_now + $urandom_range(0, 40);
      span = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 96);
      cid  = ($urandom_range(0, 7) == 0) ? ID_BITS'($urandom)
                                         : ID_BITS'(id_guess - $urandom_range(1, 20));
      if (pick < 25) begin
         send_req(OP_ADD_ONESHOT, tick_now, span, ID_BITS'($urandom));
         id_guess++;
      end else if (pick < 45) begin
         send_req(OP_ADD_PERIODIC, tick_now, span, ID_BITS'($urandom));
         id_guess++;
      end else if (pick < 65) begin
         send_req(OP_CANCEL, tick_now, $urandom, cid);
      end else begin
         send_req(OP_TICK, tick_now, $urandom, ID_BITS'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_req(OP_TICK, '0, '0, '0);
      send_req(OP_CANCEL, BASE_T, '0, '0);
      send_req(OP_ADD_ONESHOT, BASE_T, 32'h4000_0000, '0);
      // fill slots 1..15, hit the full table once, then fire them all
      for (int r = 0; r < FILL_ROUNDS; r++) begin
         repeat (NUM_SLOTS - 1) send_req(OP_ADD_ONESHOT, BASE_T, '0, '0);
         if (r == 0)
            send_req(OP_ADD_ONESHOT, BASE_T, '0, '0);
         send_req(OP_TICK, BASE_T + 1, '0, '0);
      end
      send_req(OP_ADD_PERIODIC, BASE_T, '1, '0);
      send_req(OP_CANCEL, BASE_T, '0, '0);
      send_req(OP_TICK, BASE_T - 1, '0, '0);
      send_req(OP_ADD_ONESHOT, BASE_T, 32'h8000_0000, '0);
      send_req(OP_ADD_ONESHOT, BASE_T, 32'h7fff_ffff, '0);
      send_req(OP_TICK, BASE_T, '0, '0);
      send_req(OP_TICK, BASE_T + 32'hffff_fffe, '0, '0);
      send_req(OP_ADD_ONESHOT, '1, '0, '0);
      send_req(OP_TICK, BASE_T, '0, '0);
      send_req(OP_CANCEL, BASE_T, '0, '1);
      send_req(OP_CANCEL, BASE_T, '0, '0);
      send_req(OP_TICK, '1, '1, '1);
      id_guess = 16'd35;
      tick_now = BASE_T;

      req_idle_pct = 14;
      rsp_idle_pct <= 86;
      repeat (RANDOM_REQS) send_random_req();
      pause_for_results();

      req_idle_pct = 86;
      rsp_idle_pct <= 14;
      repeat (RANDOM_REQS) send_random_req();

      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      for (int k = 0; k < RANDOM_REQS; k++) begin
         if (k == 5)
            hold_toggle <= ~hold_toggle;
         send_random_req();
      end

      pause_for_results();
      repeat (2 * NUM_SLOTS + 8) @(negedge clock);
      if (error_count == 0 && awaited_count == 0) begin
         $display("oneshot_periodic_timer_table_test: clean");
      end else begin
         $display("oneshot_periodic_timer_table_test: errors");
      end
      $finish;
   end

endmodule
